// ===== src/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned IdxW  = 2;

	// result and phase codes
	typedef enum logic [3:0] {
		CODE_FILTERED    = 4'd0,
		CODE_IDLE        = 4'd1,
		CODE_PRESS1      = 4'd2,
		CODE_HOLD1       = 4'd3,
		CODE_RELEASE1    = 4'd4,
		CODE_WAIT2       = 4'd5,
		CODE_PRESS2      = 4'd6,
		CODE_HOLD2       = 4'd7,
		CODE_RELEASE2    = 4'd8,
		CODE_WAIT3       = 4'd9,
		CODE_LONGPRESS   = 4'd10,
		CODE_LONGHOLD    = 4'd11,
		CODE_LONGRELEASE = 4'd12
	} code_t;

	// configuration register indexes
	localparam logic [IdxW-1:0] REG_CHATTER    = 2'd0;
	localparam logic [IdxW-1:0] REG_HOLD_LIMIT = 2'd1;
	localparam logic [IdxW-1:0] REG_WAIT_LIMIT = 2'd2;

	localparam logic [CfgW-1:0] CHATTER_RST    = 16'd20;
	localparam logic [CfgW-1:0] HOLD_LIMIT_RST = 16'd1000;
	localparam logic [CfgW-1:0] WAIT_LIMIT_RST = 16'd300;

	typedef struct packed {
		logic [CfgW-1:0] chatter_ms;
		logic [CfgW-1:0] hold_limit_ms;
		logic [CfgW-1:0] wait_limit_ms;
	} cfg_t;

	typedef struct packed {
		logic             level_high;
		logic [TimeW-1:0] now_ms;
	} sample_t;

endpackage

// ===== src/bcc_if.sv =====
// ----------------------------------------------------------------------------
// bcc interfaces
// Sample, result and configuration channels of the button click classifier.
// ----------------------------------------------------------------------------
interface bcc_in_if import bcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             level_high;
	logic [TimeW-1:0] now_ms;

	modport source (output valid, level_high, now_ms, input ready);
	modport sink (input valid, level_high, now_ms, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [3:0] state_code;

	modport source (output valid, state_code, input ready);
	modport sink (input valid, state_code, output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] index;
	logic [CfgW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Configuration registers: debounce gap, long press time, double click wait.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
	import bcc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	bcc_cfg_if.sink        cfg,
	output cfg_t           cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chatter_ms    <= CHATTER_RST;
			cfg_q.hold_limit_ms <= HOLD_LIMIT_RST;
			cfg_q.wait_limit_ms <= WAIT_LIMIT_RST;
		end else if (cfg.valid) begin
			// writes beyond the last register are dropped
			unique case (cfg.index)
				REG_CHATTER:    cfg_q.chatter_ms    <= cfg.data;
				REG_HOLD_LIMIT: cfg_q.hold_limit_ms <= cfg.data;
				REG_WAIT_LIMIT: cfg_q.wait_limit_ms <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/bcc_core.sv =====
// ----------------------------------------------------------------------------
// bcc_core
// Debounce gate and press/hold/release phase machine, one sample per cycle while step is set.
// ----------------------------------------------------------------------------
module bcc_core
	import bcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg_q,
	input  logic    step,
	input  sample_t smp,
	output code_t   code
);

	code_t            phase_q;
	logic [TimeW-1:0] last_accept_q;
	logic [TimeW-1:0] phase_start_q;

	logic [TimeW-1:0] gap;
	logic [TimeW-1:0] elapsed;
	logic             take;
	logic             hold_over;
	logic             wait_over;
	logic             restart;
	code_t            next_phase;

	assign gap       = smp.now_ms - last_accept_q;
	assign elapsed   = smp.now_ms - phase_start_q;
	assign take      = gap > {{(TimeW-CfgW){1'b0}}, cfg_q.chatter_ms};
	assign hold_over = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_q.hold_limit_ms};
	assign wait_over = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_q.wait_limit_ms};

	always_comb begin
		next_phase = CODE_IDLE;
		restart    = 1'b0;
		unique case (phase_q)
			CODE_IDLE: next_phase = smp.level_high ? CODE_PRESS1 : CODE_IDLE;
			CODE_PRESS1: begin
				next_phase = smp.level_high ? CODE_HOLD1 : CODE_RELEASE1;
				restart    = smp.level_high;
			end
			CODE_HOLD1: begin
				if (!smp.level_high) next_phase = CODE_RELEASE1;
				else next_phase = hold_over ? CODE_LONGPRESS : CODE_HOLD1;
			end
			CODE_RELEASE1: begin
				next_phase = smp.level_high ? CODE_PRESS2 : CODE_WAIT2;
				restart    = !smp.level_high;
			end
			CODE_WAIT2, CODE_WAIT3: begin
				if (smp.level_high) next_phase = CODE_PRESS2;
				else next_phase = wait_over ? CODE_IDLE : phase_q;
			end
			CODE_PRESS2: begin
				next_phase = smp.level_high ? CODE_HOLD2 : CODE_RELEASE2;
				restart    = smp.level_high;
			end
			CODE_HOLD2: begin
				if (!smp.level_high) next_phase = CODE_RELEASE2;
				else next_phase = hold_over ? CODE_LONGPRESS : CODE_HOLD2;
			end
			CODE_RELEASE2: begin
				next_phase = smp.level_high ? CODE_PRESS2 : CODE_WAIT3;
				restart    = !smp.level_high;
			end
			CODE_LONGPRESS, CODE_LONGHOLD:
				next_phase = smp.level_high ? CODE_LONGHOLD : CODE_LONGRELEASE;
			CODE_LONGRELEASE: next_phase = smp.level_high ? CODE_PRESS1 : CODE_IDLE;
			default: next_phase = CODE_IDLE;
		endcase
	end

	assign code = take ? next_phase : CODE_FILTERED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= CODE_IDLE;
			last_accept_q <= '0;
			phase_start_q <= '0;
		end else if (step && take) begin
			phase_q       <= next_phase;
			last_accept_q <= smp.now_ms;
			if (restart) phase_start_q <= smp.now_ms;
		end
	end

`ifndef SYNTHESIS
	// filtered samples leave the machine alone
	a_filter_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !take) |=> ($stable(phase_q) && $stable(last_accept_q)
			&& $stable(phase_start_q)))
		else $error("filtered sample changed state");

	// the phase register never holds the filtered code
	a_phase_not_filtered: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != CODE_FILTERED)
		else $error("phase holds filtered code");

	// an accepted sample records its timestamp
	a_last_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(step && take) |=> (last_accept_q == $past(smp.now_ms)))
		else $error("last accepted time not recorded");

	// the timer restarts only on entry into a hold or wait phase
	a_restart_target: assert property (@(posedge clk) disable iff (!arst_n)
		(step && take && restart) |=> (phase_q == CODE_HOLD1 || phase_q == CODE_HOLD2
			|| phase_q == CODE_WAIT2 || phase_q == CODE_WAIT3))
		else $error("timer restart on wrong transition");
`endif

endmodule

// ===== src/button_click_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Button press classifier: debounce gate and phase machine between an input
// register and a result register.
// ----------------------------------------------------------------------------
// path: an accepted sample is registered in stage 1, its result code in stage 2
// throughput: one sample per cycle while the result side is ready
// a stalled result fills both stages, then the sample channel is held off
// reset: asynchronous active low; config to 20/1000/300 ms, phase idle,
// timestamps zero, both pipeline stages empty
module button_click_classifier_unit
	import bcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	bcc_in_if.sink   sample,
	bcc_out_if.source result,
	bcc_cfg_if.sink  cfg
);

	cfg_t    cfg_q;
	logic    valid_s1;
	sample_t smp_s1;
	logic    valid_s2;
	code_t   code_s2;
	code_t   code;
	logic    advance;

	bcc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	bcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_q  (cfg_q),
		.step   (advance),
		.smp    (smp_s1),
		.code   (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			smp_s1.level_high <= sample.level_high;
			smp_s1.now_ms     <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) code_s2 <= code;
	end

	assign result.valid      = valid_s2;
	assign result.state_code = code_s2;

`ifndef SYNTHESIS
	// a sample moving out of stage 1 always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced transaction lost");

	// an empty input stage never stalls the sample channel
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample.ready)
		else $error("input stalled while empty");

	// stage 1 never advances into an occupied, stalled result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |-> !advance)
		else $error("result overwritten");

	// result codes stay within the defined range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (code_s2 <= CODE_LONGRELEASE))
		else $error("result code out of range");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click classifier. Samples are timed as
// button gestures (clicks, double clicks, long holds) with debounce noise,
// threshold-edge timing and timestamp wrap, and each result code is compared
// against an in-bench model of the debounce gate and phase machine.
// ----------------------------------------------------------------------------
module tb;
	import bcc_pkg::*;

	localparam logic [IdxW-1:0] REG_SPARE = 2'd3; // decodes to no register

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bcc_in_if  sample_ch();
	bcc_out_if result_ch();
	bcc_cfg_if cfg_ch();

	button_click_classifier_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// classifier model state
	cfg_t             timing;
	code_t            held_phase;
	logic [TimeW-1:0] accept_stamp;
	logic [TimeW-1:0] phase_stamp;

	code_t            expected_codes[$];
	int unsigned      err_count = 0;
	logic [TimeW-1:0] clock_ms = '0;
	bit               src_idle = 1'b0;
	bit               sink_stall = 1'b0;

	task automatic report(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic code_t classify_sample(input logic lvl, input logic [TimeW-1:0] now);
		logic [TimeW-1:0] gap;
		logic [TimeW-1:0] held;
		code_t nxt;
		gap = now - accept_stamp;
		held = now - phase_stamp;
		if (gap <= TimeW'(timing.chatter_ms))
			return CODE_FILTERED;
		nxt = CODE_IDLE;
		case (held_phase)
			CODE_IDLE: begin
				if (lvl) nxt = CODE_PRESS1;
			end
			CODE_PRESS1: begin
				if (lvl) begin
					phase_stamp = now;
					nxt = CODE_HOLD1;
				end else nxt = CODE_RELEASE1;
			end
			CODE_HOLD1, CODE_HOLD2: begin
				if (!lvl) nxt = (held_phase == CODE_HOLD1) ? CODE_RELEASE1 : CODE_RELEASE2;
				else if (held > TimeW'(timing.hold_limit_ms)) nxt = CODE_LONGPRESS;
				else nxt = held_phase;
			end
			CODE_RELEASE1, CODE_RELEASE2: begin
				if (lvl) nxt = CODE_PRESS2;
				else begin
					phase_stamp = now;
					nxt = (held_phase == CODE_RELEASE1) ? CODE_WAIT2 : CODE_WAIT3;
				end
			end
			CODE_WAIT2, CODE_WAIT3: begin
				if (lvl) nxt = CODE_PRESS2;
				else if (held > TimeW'(timing.wait_limit_ms)) nxt = CODE_IDLE;
				else nxt = held_phase;
			end
			CODE_PRESS2: begin
				if (lvl) begin
					phase_stamp = now;
					nxt = CODE_HOLD2;
				end else nxt = CODE_RELEASE2;
			end
			CODE_LONGPRESS, CODE_LONGHOLD: begin
				nxt = lvl ? CODE_LONGHOLD : CODE_LONGRELEASE;
			end
			CODE_LONGRELEASE: begin
				if (lvl) nxt = CODE_PRESS1;
			end
			default: nxt = CODE_IDLE;
		endcase
		held_phase = nxt;
		accept_stamp = now;
		return nxt;
	endfunction

	// result side: random stall bursts while sink_stall is set
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0 && sink_stall) begin
				stall_left--;
				if (stall_left == 0) result_ch.ready <= 1'b1;
			end else if (sink_stall && $urandom_range(0, 11) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 19);
			end else begin
				stall_left = 0;
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		code_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_codes.size() == 0) begin
				report($sformatf("unexpected result code %0d", result_ch.state_code));
			end else begin
				want = expected_codes.pop_front();
				if (result_ch.state_code !== want)
					report($sformatf("state_code %0d, want %0d (%s)",
						result_ch.state_code, want, want.name()));
			end
		end
	end

	// one sample transaction; valid is left high for a following sample
	task automatic send_sample(input logic lvl, input logic [TimeW-1:0] now);
		sample_ch.valid <= 1'b1;
		sample_ch.level_high <= lvl;
		sample_ch.now_ms <= now;
		do @(posedge clk); while (!sample_ch.ready);
		expected_codes.push_back(classify_sample(lvl, now));
	endtask

	task automatic tap(input logic lvl, input logic [TimeW-1:0] dt);
		if (src_idle && $urandom_range(0, 9) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		clock_ms += dt;
		send_sample(lvl, clock_ms);
	endtask

	task automatic await_results();
		sample_ch.valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// writes all three registers plus the unused index, which must be ignored
	task automatic load_timing(input logic [CfgW-1:0] chatter, input logic [CfgW-1:0] lp,
		input logic [CfgW-1:0] dc);
		logic [IdxW-1:0] idx_list[4];
		logic [CfgW-1:0] val_list[4];
		idx_list = '{REG_CHATTER, REG_HOLD_LIMIT, REG_WAIT_LIMIT, REG_SPARE};
		val_list = '{chatter, lp, dc, CfgW'($urandom())};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx_list[i];
			cfg_ch.data <= val_list[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (idx_list[i])
				REG_CHATTER:    timing.chatter_ms = val_list[i];
				REG_HOLD_LIMIT: timing.hold_limit_ms = val_list[i];
				REG_WAIT_LIMIT: timing.wait_limit_ms = val_list[i];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// last accepted time starts at zero, so early stamps are filtered
	task automatic test_first_samples();
		tap(1'b1, 0);
		tap(1'b1, 20);
		tap(1'b0, 1);
	endtask

	task automatic test_phase_walk();
		tap(1'b1, 21);   // press1
		tap(1'b0, 21);   // release1
		tap(1'b1, 21);   // press2
		tap(1'b1, 21);   // hold2, timer starts
		tap(1'b1, 1000); // exactly the hold limit: still holding
		tap(1'b1, 21);   // longpress
		tap(1'b1, 21);   // longhold
		tap(1'b0, 21);   // longrelease
		tap(1'b1, 21);   // press1
		tap(1'b1, 21);   // hold1
		tap(1'b1, 1001); // one past the hold limit
		tap(1'b0, 21);   // longrelease
		tap(1'b0, 21);   // idle
		tap(1'b1, 21);
		tap(1'b0, 21);
		tap(1'b0, 21);   // wait2, timer starts
		tap(1'b0, 300);  // exactly the wait limit: still waiting
		tap(1'b1, 21);   // press2
		tap(1'b0, 21);   // release2
		tap(1'b0, 21);   // wait3
		tap(1'b0, 301);  // times out to idle
	endtask

	task automatic test_time_edges();
		await_results();
		load_timing('0, '0, '0);
		tap(1'b1, 0);    // zero gap never passes
		tap(1'b1, 1);
		await_results();
		load_timing('1, '1, '1);
		tap(1'b0, 32'd65535);
		tap(1'b0, 32'd65536);
		tap(1'b1, 32'hFFFF_FFFF - clock_ms);
		tap(1'b1, 32'd65536); // stamp wraps through zero
	endtask

	task automatic test_random_gestures(input int unsigned phases, input int unsigned per_phase);
		logic             lvl;
		logic [TimeW-1:0] dt;
		int unsigned      run_left;
		int unsigned      r;
		lvl = 1'b0;
		run_left = 0;
		for (int p = 0; p < phases; p++) begin
			await_results();
			case ($urandom_range(0, 5))
				0: load_timing('0, '0, '0);
				1: load_timing('1, '1, '1);
				2: load_timing(CHATTER_RST, HOLD_LIMIT_RST, WAIT_LIMIT_RST);
				5: load_timing(CfgW'($urandom()), CfgW'($urandom()), CfgW'($urandom()));
				default: load_timing(CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 400)),
					CfgW'($urandom_range(0, 300)));
			endcase
			if ($urandom_range(0, 2) == 0)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			else
				clock_ms = $urandom();
			src_idle = (p != phases - 1) && ($urandom_range(0, 2) != 0);
			sink_stall = (p != phases - 1) && ($urandom_range(0, 2) != 0);
			for (int i = 0; i < per_phase; i++) begin
				if (run_left == 0) begin
					lvl = ~lvl;
					run_left = $urandom_range(1, 6);
				end
				run_left--;
				r = $urandom_range(0, 99);
				if (r < 8) dt = $urandom_range(0, timing.chatter_ms);
				else if (r < 70) dt = timing.chatter_ms + 1 + $urandom_range(0, 60);
				else if (r < 82) dt = timing.hold_limit_ms + $urandom_range(0, 1);
				else if (r < 94) dt = timing.wait_limit_ms + $urandom_range(0, 1);
				else dt = $urandom();
				// a stray level now and then against the current run
				if ($urandom_range(0, 19) == 0) tap(1'($urandom_range(0, 1)), dt);
				else tap(lvl, dt);
			end
		end
	endtask

	initial begin
		timing = '{CHATTER_RST, HOLD_LIMIT_RST, WAIT_LIMIT_RST};
		held_phase = CODE_IDLE;
		accept_stamp = '0;
		phase_stamp = '0;
		sample_ch.valid <= 1'b0;
		sample_ch.level_high <= 1'b0;
		sample_ch.now_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 1'b1;
		sink_stall = 1'b1;
		test_first_samples();
		test_phase_walk();
		test_time_edges();
		test_random_gestures(8, 102);

		sample_ch.valid <= 1'b0;
		for (int i = 0; i < 20000 && expected_codes.size() != 0; i++) @(posedge clk);
		repeat (4) @(posedge clk);
		if (expected_codes.size() != 0)
			report($sformatf("%0d results never arrived", expected_codes.size()));
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule
